// ===== src/tigs_pkg.sv =====
// Shared constants and types of the time interval grid splitter.
package tigs_pkg;

  localparam int TIME_W       = 32;
  localparam int DUR_W        = 31;
  localparam int TAG_W        = 32;
  localparam int IDX_W        = 5;
  localparam int CNT_W        = 6;
  localparam int MAX_SEGS     = 32;
  localparam int GRID_DEPTH_D = 32;

  localparam int S_DATA_W = 136;
  localparam int M_DATA_W = 96;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_ORDER      = 2'd1,
    ERR_NEG_START  = 2'd2,
    ERR_BELOW_GRID = 2'd3
  } err_e;

endpackage

// ===== src/tigs_grid_ram.sv =====
// Grid point store: one write port, one registered read port.
module tigs_grid_ram
  import tigs_pkg::*;
#(
  parameter int DEPTH = GRID_DEPTH_D,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [TIME_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [TIME_W-1:0] rdata_o
);

  logic [TIME_W-1:0] mem_q [DEPTH];
  logic [TIME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/time_interval_grid_splitter_core.sv =====
// Top level of the time interval grid splitter: control, scan and output register.
//
// Channel  | Dir | Beat content (lowest bit first)
// ---------+-----+-----------------------------------------------------------------
// s_axis   | in  | tuser: op; tdata: grid_index, grid_value, start_time, end_time,
//          |     |        event_in, row_tag, 2 pad bits
// m_axis   | out | tuser: error; tlast: last;
//          |     | tdata: seg_start, seg_duration, seg_event, seg_tag
// cfg      | in  | data: grid_count
//
// A split walks the grid one entry per cycle, while the output side does not
// stall, through the registered read port of the grid memory. Each segment is
// loaded into the output register when its closing grid point is evaluated
// and is presented on m_axis in the cycle after.
// Reset clears control state and sets grid_count to 1; grid contents are
// undefined until written. A stalled output holds the scan in place.
module time_interval_grid_splitter_core
  import tigs_pkg::*;
#(
  parameter int GRID_DEPTH = GRID_DEPTH_D
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,  // grid_index, grid_value, start_time,
                                               // end_time, event_in, row_tag, pad
  input  logic                s_axis_tuser_i,  // op
  // master side
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,  // seg_start, seg_duration, seg_event,
                                               // seg_tag
  output logic [1:0]          m_axis_tuser_o,  // error
  output logic                m_axis_tlast_o,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CNT_W-1:0]    cfg_data_i       // grid_count
);

  localparam int AW   = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
  localparam int NMAX = (GRID_DEPTH < MAX_SEGS) ? GRID_DEPTH : MAX_SEGS;
  localparam int CW   = $clog2(NMAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_e;

  // Input beat fields
  logic                     in_op;
  logic [IDX_W-1:0]         in_idx;
  logic [TIME_W-1:0]        in_gval;
  logic signed [TIME_W-1:0] in_start;
  logic signed [TIME_W-1:0] in_end;
  logic                     in_ev;
  logic [TAG_W-1:0]         in_tag;

  assign in_op    = s_axis_tuser_i;
  assign in_idx   = s_axis_tdata_i[4:0];
  assign in_gval  = s_axis_tdata_i[36:5];
  assign in_start = s_axis_tdata_i[68:37];
  assign in_end   = s_axis_tdata_i[100:69];
  assign in_ev    = s_axis_tdata_i[101];
  assign in_tag   = s_axis_tdata_i[133:102];

  state_e                   state_q, state_d;
  logic [CW-1:0]            k_q, k_d;
  logic                     found_q, found_d;
  logic signed [TIME_W-1:0] cur_q, cur_d;
  logic signed [TIME_W-1:0] pos_q, pos_d;
  logic signed [TIME_W-1:0] start_q, start_d;
  logic signed [TIME_W-1:0] end_q, end_d;
  logic                     ev_q, ev_d;
  logic [TAG_W-1:0]         tag_q, tag_d;
  err_e                     err_q, err_d;
  logic [CNT_W-1:0]         grid_count_q;

  logic                     m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0]      m_data_q, m_data_d;
  logic [1:0]               m_user_q, m_user_d;
  logic                     m_last_q, m_last_d;

  // Memory port signals
  logic                     we;
  logic [AW-1:0]            waddr;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [TIME_W-1:0]        rdata;
  logic signed [TIME_W-1:0] g;

  logic                     s_acc;
  logic                     slot_free;
  logic [CW-1:0]            n_eff;
  logic [CW-1:0]            k_inc;
  logic                     k_done;
  logic [TIME_W-1:0]        seg_diff;
  logic [TIME_W-1:0]        end_diff;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  // Writes with an index past the memory are dropped
  assign we    = s_acc && !in_op && (32'(in_idx) < GRID_DEPTH);
  assign waddr = AW'(in_idx);
  assign g     = rdata;

  // Entries in use: zero counts as one, saturate at the smaller limit
  always_comb begin
    if (grid_count_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(grid_count_q) > NMAX) begin
      n_eff = CW'(NMAX);
    end else begin
      n_eff = CW'(grid_count_q);
    end
  end

  assign k_inc    = k_q + CW'(1);
  assign k_done   = (k_inc >= n_eff);
  assign seg_diff = g - pos_q;
  assign end_diff = end_q - pos_q;

  tigs_grid_ram #(
    .DEPTH (GRID_DEPTH),
    .AW    (AW)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_gval),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    logic emit;
    logic stop;
    logic adv;
    emit = 1'b0;
    stop = 1'b0;
    adv  = 1'b0;

    state_d   = state_q;
    k_d       = k_q;
    found_d   = found_q;
    cur_d     = cur_q;
    pos_d     = pos_q;
    start_d   = start_q;
    end_d     = end_q;
    ev_d      = ev_q;
    tag_d     = tag_q;
    err_d     = err_q;
    re        = 1'b0;
    raddr     = '0;

    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;

    case (state_q)
      ST_IDLE: begin
        if (s_acc && in_op) begin
          start_d = in_start;
          end_d   = in_end;
          ev_d    = in_ev;
          tag_d   = in_tag;
          pos_d   = in_start;
          cur_d   = '0;
          k_d     = '0;
          found_d = 1'b0;
          if (in_end <= in_start) begin
            err_d   = ERR_ORDER;
            state_d = ST_FINAL;
          end else if (in_start < 0) begin
            err_d   = ERR_NEG_START;
            state_d = ST_FINAL;
          end else begin
            // Fetch the first grid point
            err_d   = ERR_NONE;
            re      = 1'b1;
            raddr   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (k_q == '0 && g > start_q) begin
          err_d   = ERR_BELOW_GRID;
          state_d = ST_FINAL;
        end else if (!found_q && g < start_q) begin
          // Still below the start: track the snap point
          cur_d = g;
          adv   = 1'b1;
        end else if (!found_q && g == start_q) begin
          cur_d   = g;
          found_d = 1'b1;
          adv     = 1'b1;
        end else begin
          // Split point candidate
          found_d = 1'b1;
          if (g < end_q) begin
            emit = 1'b1;
          end else begin
            stop = 1'b1;
          end
        end

        if (emit) begin
          if (slot_free) begin
            m_valid_d = 1'b1;
            m_data_d  = {tag_q, 1'b0, seg_diff[DUR_W-1:0], cur_q};
            m_user_d  = ERR_NONE;
            m_last_d  = 1'b0;
            cur_d     = g;
            pos_d     = g;
            adv       = 1'b1;
          end else begin
            // Hold: the read data register keeps this entry
            found_d = found_q;
          end
        end

        if (stop) begin
          state_d = ST_FINAL;
        end else if (adv) begin
          if (k_done) begin
            state_d = ST_FINAL;
          end else begin
            k_d   = k_inc;
            re    = 1'b1;
            raddr = AW'(k_inc);
          end
        end
      end

      ST_FINAL: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_user_d  = err_q;
          m_last_d  = 1'b1;
          if (err_q == ERR_NONE) begin
            m_data_d = {tag_q, ev_q, end_diff[DUR_W-1:0], cur_q};
          end else begin
            m_data_d = {tag_q, 1'b0, {DUR_W{1'b0}}, {TIME_W{1'b0}}};
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      found_q      <= 1'b0;
      err_q        <= ERR_NONE;
      m_valid_q    <= 1'b0;
      grid_count_q <= CNT_W'(1);
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      found_q   <= found_d;
      err_q     <= err_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        grid_count_q <= cfg_data_i;
      end
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    pos_q    <= pos_d;
    start_q  <= start_d;
    end_q    <= end_d;
    ev_q     <= ev_d;
    tag_q    <= tag_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule
